// ===== sv/ssr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the stream substring replace unit.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int CHAR_W       = 8;
    localparam int WINDOW_SLOTS = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES    = 2'd0,
        CFG_PATTERN_LENGTH   = 2'd1,
        CFG_SUBSTITUTE_BYTES = 2'd2,
        CFG_SUBSTITUTE_LENGTH = 2'd3
    } cfg_index_t;

    typedef logic [WINDOW_SLOTS-1:0][CHAR_W-1:0] window_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       out_last;
        logic       pattern_error;
    } out_item_t;

    // One accepted character turned into a list of results:
    // seq[0 .. head_count-1], then substitute[0 .. sub_count-1], then an
    // optional bare end marker.
    typedef struct packed {
        window_t    seq;
        logic [3:0] head_count;
        logic [3:0] sub_count;
        logic [4:0] total;
        logic       last;
        logic       err;
    } job_t;

endpackage

`default_nettype wire

// ===== sv/ssr_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssr_match
// Appends the new character to the window, finds the shortest drop that
// leaves a pattern prefix, detects a full match and builds the result list.
// ----------------------------------------------------------------------------
module ssr_match (
    input  wire ssr_pkg::window_t  window,
    input  wire logic [3:0]        fill,
    input  wire ssr_pkg::in_item_t item,
    input  wire logic [63:0]       pattern_bytes,
    input  wire logic [3:0]        plen,
    input  wire logic [3:0]        slen,
    output ssr_pkg::job_t          job,
    output ssr_pkg::window_t       window_next,
    output logic [3:0]             fill_next
);

    ssr_pkg::window_t seq;
    ssr_pkg::window_t pat;
    logic [3:0]       seq_len;
    logic [8:0]       cand_ok;
    logic [3:0]       drop;
    logic [3:0]       keep;
    logic             hit;
    logic             no_pattern;
    logic             marker;
    logic [3:0]       head;
    logic [3:0]       subs;

    assign pat        = pattern_bytes;
    assign seq_len    = fill + 4'd1;
    assign no_pattern = (plen == 4'd0);

    always_comb
    begin
        seq = window;
        seq[fill[2:0]] = item.in_char;
    end

    // A drop of k is good when the remaining characters are a prefix of the pattern
    always_comb
    begin
        for (int k = 0; k <= 8; k++)
        begin
            cand_ok[k] = 1'b1;
            if (4'(k) < seq_len)
            begin
                if ((seq_len - 4'(k)) > plen)
                    cand_ok[k] = 1'b0;
                for (int j = 0; j < 8 - k; j++)
                begin
                    if ((4'(j) < (seq_len - 4'(k))) && (seq[k + j] != pat[j]))
                        cand_ok[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        drop = 4'd8;
        for (int k = 8; k >= 0; k--)
        begin
            if (cand_ok[k])
                drop = 4'(k);
        end
    end

    assign keep = seq_len - drop;
    assign hit  = !no_pattern && (keep == plen);

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            window_next[j] = seq[j];
            for (int kk = 0; kk < 8 - j; kk++)
            begin
                if (drop == 4'(kk))
                    window_next[j] = seq[j + kk];
            end
        end
    end

    always_comb
    begin
        if (no_pattern)
        begin
            head      = seq_len;
            subs      = 4'd0;
            fill_next = 4'd0;
        end
        else if (hit)
        begin
            head      = drop;
            subs      = slen;
            fill_next = 4'd0;
        end
        else if (item.in_last)
        begin
            head      = seq_len;
            subs      = 4'd0;
            fill_next = 4'd0;
        end
        else
        begin
            head      = drop;
            subs      = 4'd0;
            fill_next = keep;
        end
    end

    assign marker = item.in_last && (head == 4'd0) && (subs == 4'd0);

    always_comb
    begin
        job.seq        = seq;
        job.head_count = head;
        job.sub_count  = subs;
        job.total      = {1'b0, head} + {1'b0, subs} + {4'b0, marker};
        job.last       = item.in_last;
        job.err        = no_pattern;
    end

endmodule

`default_nettype wire

// ===== sv/ssr_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssr_emit
// Holds one result list and sends it out one transaction per cycle through
// the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module ssr_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ssr_pkg::job_t  job_in,
    input  wire logic           job_load,
    input  wire logic [63:0]    substitute_bytes,
    output logic                job_ready,
    output logic                dst_valid,
    input  wire logic           dst_ready,
    output ssr_pkg::out_item_t  dst_item
);

    ssr_pkg::job_t      job_reg;
    ssr_pkg::job_t      job_next;
    logic               busy_reg;
    logic               busy_next;
    logic [4:0]         idx_reg;
    logic [4:0]         idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ssr_pkg::out_item_t out_item_reg;
    ssr_pkg::out_item_t out_item_next;

    ssr_pkg::window_t   sub;
    ssr_pkg::out_item_t elem;
    logic [4:0]         sub_idx;
    logic               out_free;
    logic               final_elem;
    logic               take;

    assign sub        = substitute_bytes;
    assign out_free   = !out_valid_reg || dst_ready;
    assign final_elem = busy_reg && (idx_reg == job_reg.total - 5'd1);
    assign take       = busy_reg && out_free;
    assign job_ready  = !busy_reg || (take && final_elem);
    assign sub_idx    = idx_reg - {1'b0, job_reg.head_count};

    always_comb
    begin
        elem.pattern_error = job_reg.err;
        elem.out_last      = job_reg.last && final_elem;
        if (idx_reg < {1'b0, job_reg.head_count})
        begin
            elem.out_char   = job_reg.seq[idx_reg[2:0]];
            elem.char_valid = 1'b1;
        end
        else if (idx_reg < ({1'b0, job_reg.head_count} + {1'b0, job_reg.sub_count}))
        begin
            elem.out_char   = sub[sub_idx[2:0]];
            elem.char_valid = 1'b1;
        end
        else
        begin
            elem.out_char   = 8'd0;
            elem.char_valid = 1'b0;
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_item_next  = elem;
            idx_next       = idx_reg + 5'd1;
            if (final_elem)
                busy_next = 1'b0;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (job_load)
        begin
            job_next  = job_in;
            busy_next = 1'b1;
            idx_next  = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_item_reg <= out_item_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== sv/stream_substring_replace_unit.sv =====
`default_nettype none
// Path: an accepted character's results are held in the job register and sent on
// through the output register. Throughput: one character per cycle while each yields
// at most one result and the output is not stalled; a character that yields more
// results holds src_ready low until its last result enters the output register.
// Reset: rst_n clears the configuration, the window fill and all handshake state at
// once; the window bytes themselves are not cleared.
// ----------------------------------------------------------------------------
// stream_substring_replace_unit
// Replaces each leftmost, non-overlapping pattern occurrence in a character
// stream with the configured substitute string.
// ----------------------------------------------------------------------------
module stream_substring_replace_unit #(
    parameter int MAX_PATTERN    = 8,
    parameter int MAX_SUBSTITUTE = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               src_valid,
    output logic                    src_ready,
    input  wire ssr_pkg::in_item_t  src_item,
    output logic                    dst_valid,
    input  wire logic               dst_ready,
    output ssr_pkg::out_item_t      dst_item
);

    localparam logic [3:0] PLEN_CAP = 4'((MAX_PATTERN < 8) ? MAX_PATTERN : 8);
    localparam logic [3:0] SLEN_CAP = 4'((MAX_SUBSTITUTE < 8) ? MAX_SUBSTITUTE : 8);

    logic [63:0]      pattern_bytes_reg;
    logic [3:0]       pattern_length_reg;
    logic [63:0]      substitute_bytes_reg;
    logic [3:0]       substitute_length_reg;
    ssr_pkg::window_t window_reg;
    ssr_pkg::window_t window_next;
    logic [3:0]       fill_reg;
    logic [3:0]       fill_next;

    logic [3:0]       plen;
    logic [3:0]       slen;
    ssr_pkg::job_t    job;
    logic             accept;
    logic             job_ready;

    assign plen = (pattern_length_reg > PLEN_CAP) ? PLEN_CAP : pattern_length_reg;
    assign slen = (substitute_length_reg > SLEN_CAP) ? SLEN_CAP : substitute_length_reg;

    assign src_ready = job_ready;
    assign accept    = src_valid && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg     <= 64'd0;
            pattern_length_reg    <= 4'd0;
            substitute_bytes_reg  <= 64'd0;
            substitute_length_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssr_pkg::CFG_PATTERN_BYTES:     pattern_bytes_reg     <= cfg_data;
                ssr_pkg::CFG_PATTERN_LENGTH:    pattern_length_reg    <= cfg_data[3:0];
                ssr_pkg::CFG_SUBSTITUTE_BYTES:  substitute_bytes_reg  <= cfg_data;
                ssr_pkg::CFG_SUBSTITUTE_LENGTH: substitute_length_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    ssr_match u_match (
        .window        (window_reg),
        .fill          (fill_reg),
        .item          (src_item),
        .pattern_bytes (pattern_bytes_reg),
        .plen          (plen),
        .slen          (slen),
        .job           (job),
        .window_next   (window_next),
        .fill_next     (fill_next)
    );

    // Advance the window on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 4'd0;
        else if (accept)
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

    ssr_emit u_emit (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_in           (job),
        .job_load         (accept && (job.total != 5'd0)),
        .substitute_bytes (substitute_bytes_reg),
        .job_ready        (job_ready),
        .dst_valid        (dst_valid),
        .dst_ready        (dst_ready),
        .dst_item         (dst_item)
    );

endmodule

`default_nettype wire

// ===== sv/ssr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks on the result stream of the substring replace unit.
// ----------------------------------------------------------------------------
module ssr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               dst_valid,
    input wire logic               dst_ready,
    input wire ssr_pkg::out_item_t dst_item
);

    // Output register is empty from the first clock seen in reset
    assert property (@(posedge clk) !rst_n |=> !dst_valid)
        else $error("result valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid)
        else $error("result transaction withdrawn");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> $stable(dst_item))
        else $error("stalled result changed");

    // A bare end marker only ever closes a string
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_item.char_valid |-> dst_item.out_last)
        else $error("end marker without last flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_item.char_valid |-> (dst_item.out_char == 8'd0))
        else $error("end marker carries a character");

endmodule

bind stream_substring_replace_unit ssr_checker u_ssr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_item  (dst_item)
);

`default_nettype wire

// ===== tb/sv/ssr_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssr_result_checker
// Watches the configuration port and both streaming channels of the
// substring replace unit, predicts the result characters of every accepted
// transaction and compares them in order with what the unit delivers.
// ----------------------------------------------------------------------------
module ssr_result_checker #(
    parameter int MAX_PATTERN    = 8,
    parameter int MAX_SUBSTITUTE = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                src_valid,
    input  logic                src_ready,
    input  ssr_pkg::in_item_t   src_item,
    input  logic                dst_valid,
    input  logic                dst_ready,
    input  ssr_pkg::out_item_t  dst_item,
    output int                  mismatch_count,
    output int                  outstanding_results
);

    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] sub_bytes;
    logic [3:0]  sub_len;

    logic [7:0]  match_bytes [ssr_pkg::WINDOW_SLOTS];
    int unsigned match_fill;
    int unsigned chars_this_step;

    ssr_pkg::out_item_t expected_chars [$];

    function automatic int unsigned clamp_len(input logic [3:0] len, input int limit);
        int unsigned cap;
        cap = (limit < ssr_pkg::WINDOW_SLOTS) ? limit : ssr_pkg::WINDOW_SLOTS;
        return (len > cap) ? cap : len;
    endfunction

    function automatic bit window_is_prefix(input int unsigned plen);
        if (match_fill > plen)
            return 1'b0;
        for (int unsigned i = 0; i < match_fill; i++)
            if (match_bytes[i] != pat_bytes[i*8 +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void drop_oldest();
        for (int unsigned i = 1; i < match_fill; i++)
            match_bytes[i-1] = match_bytes[i];
        match_fill--;
    endfunction

    function automatic void push_expected(input logic [7:0] ch, input logic valid,
                                          input logic err);
        ssr_pkg::out_item_t r;
        r.out_char      = ch;
        r.char_valid    = valid;
        r.out_last      = 1'b0;
        r.pattern_error = err;
        expected_chars.push_back(r);
        chars_this_step++;
    endfunction

    task automatic predict_replacement(input ssr_pkg::in_item_t item);
        int unsigned        plen;
        int unsigned        slen;
        logic               err;
        ssr_pkg::out_item_t tail;
        plen = clamp_len(pat_len, MAX_PATTERN);
        slen = clamp_len(sub_len, MAX_SUBSTITUTE);
        err  = (plen == 0);
        chars_this_step = 0;

        if (match_fill >= ssr_pkg::WINDOW_SLOTS)
        begin
            push_expected(match_bytes[0], 1'b1, err);
            drop_oldest();
        end
        match_bytes[match_fill] = item.in_char;
        match_fill++;

        if (plen == 0)
        begin
            // empty pattern: pass everything held straight through
            for (int unsigned i = 0; i < match_fill; i++)
                push_expected(match_bytes[i], 1'b1, err);
            match_fill = 0;
        end
        else
        begin
            while (match_fill > 0 && !window_is_prefix(plen))
            begin
                push_expected(match_bytes[0], 1'b1, err);
                drop_oldest();
            end
            if (match_fill == plen)
            begin
                for (int unsigned i = 0; i < slen; i++)
                    push_expected(sub_bytes[i*8 +: 8], 1'b1, err);
                match_fill = 0;
            end
        end

        if (item.in_last)
        begin
            for (int unsigned i = 0; i < match_fill; i++)
                push_expected(match_bytes[i], 1'b1, err);
            match_fill = 0;
            // nothing left to say: send a bare end marker
            if (chars_this_step == 0)
                push_expected(8'h00, 1'b0, err);
            tail = expected_chars.pop_back();
            tail.out_last = 1'b1;
            expected_chars.push_back(tail);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ssr_pkg::out_item_t want;
        if (!rst_n)
        begin
            pat_bytes  = '0;
            pat_len    = '0;
            sub_bytes  = '0;
            sub_len    = '0;
            match_fill = 0;
            expected_chars.delete();
            mismatch_count      = 0;
            outstanding_results = 0;
        end
        else
        begin
            // retire the delivered transaction before predicting new ones
            if (dst_valid && dst_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("result with nothing expected: out_char 0x%0h last %0b",
                           dst_item.out_char, dst_item.out_last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    check_field("out_char", want.out_char, dst_item.out_char);
                    check_field("char_valid", want.char_valid, dst_item.char_valid);
                    check_field("out_last", want.out_last, dst_item.out_last);
                    check_field("pattern_error", want.pattern_error,
                                dst_item.pattern_error);
                end
            end
            if (cfg_we)
            begin
                case (ssr_pkg::cfg_index_t'(cfg_index))
                    ssr_pkg::CFG_PATTERN_BYTES:     pat_bytes = cfg_data;
                    ssr_pkg::CFG_PATTERN_LENGTH:    pat_len   = cfg_data[3:0];
                    ssr_pkg::CFG_SUBSTITUTE_BYTES:  sub_bytes = cfg_data;
                    ssr_pkg::CFG_SUBSTITUTE_LENGTH: sub_len   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (src_valid && src_ready)
                predict_replacement(src_item);
            outstanding_results = expected_chars.size();
        end
    end

endmodule

// ===== tb/sv/tb_stream_substring_replace_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_substring_replace_unit
// Drives directed strings and random pattern-rich text through the substring
// replace unit under a range of pattern and substitute settings, with random
// stalls on both channels; the checker beside the unit judges every result.
// ----------------------------------------------------------------------------
module tb_stream_substring_replace_unit;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [63:0]        cfg_data  = '0;
    logic               src_valid = 1'b0;
    logic               src_ready;
    ssr_pkg::in_item_t  src_item  = '0;
    logic               dst_valid;
    logic               dst_ready = 1'b0;
    ssr_pkg::out_item_t dst_item;

    int          mismatch_count;
    int          outstanding_results;

    bit          steady = 1'b0;
    logic [63:0] cur_pattern = '0;
    int unsigned cur_plen    = 0;

    stream_substring_replace_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item)
    );

    ssr_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .src_valid           (src_valid),
        .src_ready           (src_ready),
        .src_item            (src_item),
        .dst_valid           (dst_valid),
        .dst_ready           (dst_ready),
        .dst_item            (dst_item),
        .mismatch_count      (mismatch_count),
        .outstanding_results (outstanding_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        dst_ready <= steady || ($urandom_range(0, 99) >= 13);

    initial
    begin
        #2000000;
        $display("stream_substring_replace_unit regression: fail");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] ch, input logic last);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid        <= 1'b1;
        src_item.in_char <= ch;
        src_item.in_last <= last;
        do
            @(posedge clk);
        while (!src_ready);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ends && (i == s.len() - 1));
    endtask

    // Hold the source off until every expected result is out, then let the
    // pipeline settle.
    task automatic wait_drained();
        src_valid <= 1'b0;
        while (outstanding_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] sub, input logic [3:0] slen);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= ssr_pkg::CFG_PATTERN_BYTES;
        cfg_data  <= pat;
        @(negedge clk);
        cfg_index <= ssr_pkg::CFG_PATTERN_LENGTH;
        cfg_data  <= {60'd0, plen};
        @(negedge clk);
        cfg_index <= ssr_pkg::CFG_SUBSTITUTE_BYTES;
        cfg_data  <= sub;
        @(negedge clk);
        cfg_index <= ssr_pkg::CFG_SUBSTITUTE_LENGTH;
        cfg_data  <= {60'd0, slen};
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_pattern = pat;
        cur_plen    = (plen > ssr_pkg::WINDOW_SLOTS) ? ssr_pkg::WINDOW_SLOTS : plen;
    endtask

    initial
    begin
        logic [63:0] pat;
        logic [63:0] sub;
        logic [3:0]  plen;
        logic [3:0]  slen;
        logic [7:0]  base;
        logic [7:0]  fragment [$];
        int          phase_items;
        int unsigned kind;
        int unsigned cut;
        bit          end_string;
        bit          broken;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pattern after reset: pass through with the error flag
        send_char(8'h61, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);

        configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_text("xabaabc", 1'b1);
        send_text("a", 1'b1);

        // empty substitute: a string made only of matches ends in a bare marker
        configure(64'h6261, 4'd2, 64'h0, 4'd0);
        send_text("ab", 1'b1);
        send_text("aba", 1'b1);

        // change the pattern while a partial match is held
        send_char(8'h61, 1'b0);
        configure(64'h6463, 4'd2, 64'h51, 4'd1);
        send_text("cd", 1'b1);

        // oversized lengths saturate to the window size
        configure({64{1'b1}}, 4'd15, 64'hFEDC_BA98_7654_3210, 4'd15);
        for (int i = 0; i < 8; i++)
            send_char(8'hFF, i == 7);

        for (int phase = 0; phase < 9; phase++)
        begin
            base = $urandom_range(0, 255);
            for (int i = 0; i < 8; i++)
                pat[i*8 +: 8] = base + 8'($urandom_range(0, 2));
            sub = {$urandom, $urandom};
            case (phase)
                0:       begin plen = 4'd0;  slen = 4'd15; end
                1:       begin plen = 4'd8;  slen = 4'd0;  end
                2:       begin plen = 4'd15; slen = 4'd8;  end
                3:       begin plen = 4'd1;  slen = 4'd2;  end
                4:       begin pat = {64{1'b1}}; sub = {64{1'b1}};
                               plen = 4'($urandom_range(1, 8)); slen = 4'd8; end
                5:       begin pat = '0; sub = '0;
                               plen = 4'($urandom_range(1, 3)); slen = 4'd1; end
                default: begin plen = 4'($urandom_range(0, 15));
                               slen = 4'($urandom_range(0, 15)); end
            endcase
            configure(pat, plen, sub, slen);
            steady = (phase == 6);

            phase_items = 0;
            while (phase_items < 22)
            begin
                kind = $urandom_range(0, 9);
                fragment.delete();
                if (kind < 5 && cur_plen != 0)
                begin
                    for (int unsigned i = 0; i < cur_plen; i++)
                        fragment.push_back(cur_pattern[i*8 +: 8]);
                end
                else if (kind < 7 && cur_plen != 0)
                begin
                    // partial match that will have to be given back
                    cut = $urandom_range(1, (cur_plen > 1) ? cur_plen - 1 : 1);
                    for (int unsigned i = 0; i < cut; i++)
                        fragment.push_back(cur_pattern[i*8 +: 8]);
                end
                else if (kind < 9)
                    fragment.push_back(cur_pattern[$urandom_range(0, 7)*8 +: 8]);
                else
                    fragment.push_back(8'($urandom_range(0, 255)));

                end_string = ($urandom_range(0, 2) == 0);
                for (int i = 0; i < fragment.size(); i++)
                begin
                    broken = ($urandom_range(0, 19) == 0);
                    send_char(fragment[i],
                              broken || (end_string && i == fragment.size() - 1));
                    phase_items++;
                end
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && outstanding_results == 0)
            $display("stream_substring_replace_unit regression: pass");
        else
            $display("stream_substring_replace_unit regression: fail");
        $finish;
    end

endmodule
